// ----- rtl/plu_pkg.sv -----
// ----------------------------------------------------------------------------
// plu_pkg
// Shared sizes, constants and controller/datapath interface types for the
// prefix lease utilisation counter.
// ----------------------------------------------------------------------------
package plu_pkg;

    localparam int SEEN_DEPTH   = 1024;
    localparam int PREFIX_SLOTS = 4;
    localparam int NUM_REGS     = 4;

    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 6;
    localparam int SLOT_W   = ADDR_W + LEN_W;
    localparam int COUNT_W  = 31;
    localparam int CFG_IDX_W = 3;
    localparam int MASK_W   = 4;

    // seen store addressing
    localparam int SEEN_AW  = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int SEEN_CW  = $clog2(SEEN_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 31'd2147483646;
    localparam logic [SEEN_CW-1:0] SEEN_FULL   = SEEN_CW'(SEEN_DEPTH);
    localparam logic [ADDR_W-1:0]  ALL_ONES    = 32'hFFFFFFFF;
    localparam logic [LEN_W-1:0]   LEN_FULL    = 6'd32;
    localparam logic [LEN_W-1:0]   LEN_MAX_HOST = 6'd30;

    // controller -> datapath
    typedef struct packed {
        logic start;     // latch a new address, restart the search
        logic search;    // walk the seen store
        logic update;    // count, store the address
        logic load_out;  // evaluate crossings, load the result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic srch_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/plu_ctrl.sv -----
// ----------------------------------------------------------------------------
// plu_ctrl
// Sequencer: accept, search the seen store, update counts, load the result.
// ----------------------------------------------------------------------------
module plu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  plu_pkg::t_dp_stat  i_stat,
    output plu_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_UPDATE = 4'b0100,
        S_CROSS  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.srch_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CROSS;
            end
            S_CROSS: begin
                // hold here until the result register can take the transaction
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/plu_datapath.sv -----
// ----------------------------------------------------------------------------
// plu_datapath
// Prefix registers, seen store with linear search, slot counters, crossing
// flags and the result register.
// ----------------------------------------------------------------------------
module plu_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  plu_pkg::t_dp_cmd                      i_cmd,
    output plu_pkg::t_dp_stat                     o_stat,
    input  logic                                  i_cfg_we,
    input  logic [plu_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [plu_pkg::SLOT_W-1:0]            i_cfg_data,
    input  logic [plu_pkg::ADDR_W-1:0]            i_assigned_address,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic                                  o_already_seen,
    output logic [plu_pkg::MASK_W-1:0]            o_matched_mask,
    output logic [plu_pkg::MASK_W-1:0]            o_crossed_mask,
    output logic                                  o_store_full,
    output logic [plu_pkg::COUNT_W-1:0]           o_count_slot_0,
    output logic [plu_pkg::COUNT_W-1:0]           o_count_slot_1,
    output logic [plu_pkg::COUNT_W-1:0]           o_count_slot_2,
    output logic [plu_pkg::COUNT_W-1:0]           o_count_slot_3
);

    logic [plu_pkg::SLOT_W-1:0]  r_slot   [plu_pkg::NUM_REGS];
    logic [plu_pkg::COUNT_W-1:0] r_counts [plu_pkg::NUM_REGS];
    logic [plu_pkg::NUM_REGS-1:0] r_crossed;

    logic [plu_pkg::ADDR_W-1:0]  r_mem [plu_pkg::SEEN_DEPTH];
    logic [plu_pkg::ADDR_W-1:0]  r_rd_data;
    logic                        r_rd_vld;
    logic [plu_pkg::SEEN_CW-1:0] r_entries;
    logic [plu_pkg::SEEN_CW-1:0] r_idx;
    logic [plu_pkg::ADDR_W-1:0]  r_addr;
    logic                        r_found;
    logic                        r_full;
    logic [plu_pkg::MASK_W-1:0]  r_matched;

    logic [plu_pkg::COUNT_W-1:0] r_out_cnt [plu_pkg::NUM_REGS];
    logic                        r_out_vld;
    logic                        r_out_seen;
    logic                        r_out_full;
    logic [plu_pkg::MASK_W-1:0]  r_out_matched;
    logic [plu_pkg::MASK_W-1:0]  r_out_crossed;

    logic                        hit_now;
    logic                        rd_issue;
    logic                        store_wr;
    logic [plu_pkg::NUM_REGS-1:0] slot_en;
    logic [plu_pkg::NUM_REGS-1:0] slot_hit;
    logic [plu_pkg::NUM_REGS-1:0] slot_cross;

    // ---- search ------------------------------------------------------------
    assign hit_now  = r_rd_vld && (r_rd_data == r_addr);
    assign rd_issue = i_cmd.search && (r_idx < r_entries) && !r_found && !hit_now;
    assign store_wr = i_cmd.update && !r_found && (r_entries < plu_pkg::SEEN_FULL);

    assign o_stat.srch_done = hit_now || r_found || ((r_idx >= r_entries) && !r_rd_vld);
    assign o_stat.out_free  = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_data <= r_mem[r_idx[plu_pkg::SEEN_AW-1:0]];
        end
        if (store_wr) begin
            r_mem[r_entries[plu_pkg::SEEN_AW-1:0]] <= r_addr;
        end
    end

    // ---- per-slot matching and crossing test ------------------------------
    always_comb begin
        logic [plu_pkg::LEN_W-1:0]  len;
        logic [plu_pkg::ADDR_W-1:0] net;
        logic [plu_pkg::ADDR_W-1:0] mask;
        logic [plu_pkg::ADDR_W-1:0] hosts;
        logic [plu_pkg::LEN_W-1:0]  sh;
        for (int s = 0; s < plu_pkg::NUM_REGS; s++) begin
            len   = r_slot[s][plu_pkg::LEN_W-1:0];
            net   = r_slot[s][plu_pkg::SLOT_W-1:plu_pkg::LEN_W];
            sh    = plu_pkg::LEN_FULL - len;
            mask  = plu_pkg::ALL_ONES << sh;
            hosts = (32'd1 << sh) - 32'd2;
            slot_en[s]  = (s < plu_pkg::PREFIX_SLOTS) && (len != '0)
                          && (len <= plu_pkg::LEN_FULL);
            slot_hit[s] = slot_en[s] && ((r_addr & mask) == net) && (r_addr != net)
                          && (r_addr != (net | ~mask));
            // lengths 31 and 32 have no hosts and never cross
            slot_cross[s] = slot_en[s] && !r_crossed[s] && (len <= plu_pkg::LEN_MAX_HOST)
                            && ({r_counts[s], 1'b0} > hosts);
        end
    end

    // ---- control and state registers --------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < plu_pkg::NUM_REGS; s++) begin
                r_slot[s]   <= '0;
                r_counts[s] <= '0;
            end
            r_crossed <= '0;
            r_entries <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index < plu_pkg::CFG_IDX_W'(plu_pkg::NUM_REGS))) begin
                r_slot[i_cfg_index[1:0]] <= i_cfg_data;
            end

            if (i_cmd.start) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.search) begin
                r_rd_vld <= rd_issue;
            end

            if (i_cmd.update) begin
                if (!r_found) begin
                    for (int s = 0; s < plu_pkg::NUM_REGS; s++) begin
                        if (slot_hit[s] && (r_counts[s] < plu_pkg::COUNT_MAX)) begin
                            r_counts[s] <= r_counts[s] + 1'b1;
                        end
                    end
                end
                if (store_wr) begin
                    r_entries <= r_entries + 1'b1;
                end
            end

            if (i_cmd.load_out) begin
                r_crossed <= r_crossed | slot_cross;
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---- payload registers ------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_addr  <= i_assigned_address;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.search) begin
            if (rd_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (hit_now) begin
                r_found <= 1'b1;
            end
        end
        if (i_cmd.update) begin
            r_full <= !r_found && (r_entries >= plu_pkg::SEEN_FULL);
            for (int s = 0; s < plu_pkg::MASK_W; s++) begin
                r_matched[s] <= !r_found && slot_hit[s];
            end
        end
        if (i_cmd.load_out) begin
            r_out_seen    <= r_found;
            r_out_full    <= r_full;
            r_out_matched <= r_matched;
            r_out_crossed <= slot_cross;
            for (int s = 0; s < plu_pkg::NUM_REGS; s++) begin
                r_out_cnt[s] <= r_counts[s];
            end
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_already_seen = r_out_seen;
    assign o_store_full   = r_out_full;
    assign o_matched_mask = r_out_matched;
    assign o_crossed_mask = r_out_crossed;
    assign o_count_slot_0 = r_out_cnt[0];
    assign o_count_slot_1 = r_out_cnt[1];
    assign o_count_slot_2 = r_out_cnt[2];
    assign o_count_slot_3 = r_out_cnt[3];

`ifndef ASSERT_OFF
    a_entries_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entries <= plu_pkg::SEEN_FULL)
        else $error("seen store fill count beyond depth");

    a_crossed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((($past(r_crossed)) & ~r_crossed) == '0))
        else $error("crossing flag cleared without reset");

    a_seen_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_seen) |-> ((r_out_matched == '0) && !r_out_full))
        else $error("repeated address reported as counted or unstored");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_counts[0] <= plu_pkg::COUNT_MAX) && (r_counts[1] <= plu_pkg::COUNT_MAX)
        && (r_counts[2] <= plu_pkg::COUNT_MAX) && (r_counts[3] <= plu_pkg::COUNT_MAX))
        else $error("slot count above saturation limit");
`endif

endmodule

// ----- rtl/prefix_lease_utilization_counter.sv -----
// ----------------------------------------------------------------------------
// prefix_lease_utilization_counter
// Counts newly assigned addresses per configured prefix, ignores repeats and
// flags the first crossing of half utilisation for each prefix.
// ----------------------------------------------------------------------------
//  channel  | handshake                      | payload
//  ---------+--------------------------------+---------------------------------
//  input    | i_in_valid / o_in_stall        | i_assigned_address
//  result   | o_out_valid / i_out_stall      | seen, masks, full, four counts
//  config   | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
//  A new address is checked against the N stored addresses (at most 1024):
//  the seen store is searched one entry per cycle through its registered
//  read port, and a repeat stops at its match. Reset clears prefixes,
//  counts, flags and the fill count; the store needs no clearing.
//  A stalled result holds; the next item is searched meanwhile and waits only
//  to load the result register.
// ----------------------------------------------------------------------------
module prefix_lease_utilization_counter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [plu_pkg::ADDR_W-1:0]            i_assigned_address,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_already_seen,
    output logic [plu_pkg::MASK_W-1:0]            o_matched_mask,
    output logic [plu_pkg::MASK_W-1:0]            o_crossed_mask,
    output logic                                  o_store_full,
    output logic [plu_pkg::COUNT_W-1:0]           o_count_slot_0,
    output logic [plu_pkg::COUNT_W-1:0]           o_count_slot_1,
    output logic [plu_pkg::COUNT_W-1:0]           o_count_slot_2,
    output logic [plu_pkg::COUNT_W-1:0]           o_count_slot_3,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [plu_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [plu_pkg::SLOT_W-1:0]            i_cfg_data
);

    plu_pkg::t_dp_cmd  dp_cmd;
    plu_pkg::t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    plu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    plu_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_stat             (dp_stat),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_assigned_address (i_assigned_address),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_already_seen     (o_already_seen),
        .o_matched_mask     (o_matched_mask),
        .o_crossed_mask     (o_crossed_mask),
        .o_store_full       (o_store_full),
        .o_count_slot_0     (o_count_slot_0),
        .o_count_slot_1     (o_count_slot_1),
        .o_count_slot_2     (o_count_slot_2),
        .o_count_slot_3     (o_count_slot_3)
    );

endmodule
